### hw/rtl/windowed_step_sequencer_defines.svh
// Assertion macros for the windowed step sequencer.
// No dependencies; included by files that carry concurrent assertions.
`ifndef WINDOWED_STEP_SEQUENCER_DEFINES_SVH
`define WINDOWED_STEP_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked on every rising clock edge outside reset.
`define WSS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Property checked on every rising clock edge, reset included.
`define WSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WSS_ASSERT(lbl, clk, rstn, prop, msg)
`define WSS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### hw/rtl/wss_pkg.sv
// Shared constants and types for the windowed step sequencer.
// No dependencies; used by windowed_step_sequencer.
package wss_pkg;

  // Command codes of an input transaction.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_OUTPUT_SCALE  = 1'b0;
  localparam logic CFG_PULSE_SAMPLES = 1'b1;

  localparam int unsigned CFG_BITS   = 16;
  localparam int unsigned CV_BITS    = 16;
  localparam int unsigned PULSE_BITS = 12;

  localparam logic signed [CV_BITS-1:0] SCALE_RESET = 16'sd3277;
  localparam logic [PULSE_BITS-1:0]     PULSE_RESET = 12'd48;

  // Control flags of a transaction between the window stage and the output stage.
  typedef struct packed {
    logic is_load;
    logic stepped;
    logic eos_fire;
  } s1_ctrl_t;

endpackage

### hw/rtl/wss_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies; instanced by windowed_step_sequencer.
module wss_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_b_i,
  output logic [WIDTH-1:0]                 rdata_a_o,
  output logic [WIDTH-1:0]                 rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### hw/rtl/windowed_step_sequencer.sv
// Windowed step sequencer: an accepted input transaction is registered in the first stage
// and then in the output register; throughput one transaction per cycle while the
// output is not stalled, with the step value RAM read in the first stage.
// Reset (asynchronous, active low) clears position, run flag, timers and the per-step valid
// bits, so every step reads as zero (no clearing pass is needed); configuration takes its reset values.
// Depends on wss_pkg, wss_ram and windowed_step_sequencer_defines.svh.
`include "windowed_step_sequencer_defines.svh"

module windowed_step_sequencer #(
  parameter int unsigned SEQ_LENGTH = 32,
  parameter int unsigned VALUE_BITS = 16,
  parameter int unsigned TIME_BITS  = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                command_i,
  input  logic                                clock_edge_i,
  input  logic                                reset_edge_i,
  input  logic                                run_toggle_i,
  input  logic [4:0]                          start_index_i,
  input  logic signed [5:0]                   window_length_i,
  input  logic signed [15:0]                  filter_level_i,
  input  logic [4:0]                          load_address_i,
  input  logic [15:0]                         load_value_i,
  input  logic                                cfg_we_i,
  input  logic                                cfg_index_i,
  input  logic [wss_pkg::CFG_BITS-1:0]        cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [4:0]                          current_step_o,
  output logic signed [wss_pkg::CV_BITS-1:0]  cv_out_o,
  output logic                                gate_o,
  output logic                                end_of_sequence_o,
  output logic                                trigger_o,
  output logic                                run_active_o
);

  localparam int unsigned IW  = $clog2(SEQ_LENGTH);
  localparam int unsigned VB  = VALUE_BITS;
  localparam int unsigned TB  = TIME_BITS;
  localparam int unsigned PB  = wss_pkg::PULSE_BITS;
  localparam logic [IW-1:0]          LAST   = IW'(SEQ_LENGTH - 1);
  localparam logic signed [9:0]      LEN_MAX = 10'(SEQ_LENGTH - 1);
  localparam logic signed [10:0]     NSTEPS = 11'(SEQ_LENGTH);
  localparam logic [VB:0]            ONE    = (VB+1)'(1) << VB;
  localparam logic signed [VB+1:0]   HALF   = (VB+2)'(1) << (VB - 1);
  localparam logic [VB-1:0]          MASK   = '1;
  localparam logic [TB-1:0]          TMAX   = '1;

  function automatic logic in_win(logic [IW-1:0] i, logic [IW-1:0] lo, logic [IW-1:0] hi);
    if (lo <= hi) begin
      return (i >= lo) && (i <= hi);
    end
    return (i >= lo) || (i <= hi);
  endfunction

  // ---------------------------------------------------------------- configuration
  logic signed [15:0] scale_q;
  logic [PB-1:0]      pulse_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= wss_pkg::SCALE_RESET;
      pulse_q <= wss_pkg::PULSE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        wss_pkg::CFG_OUTPUT_SCALE:  scale_q <= $signed(cfg_data_i[15:0]);
        wss_pkg::CFG_PULSE_SAMPLES: pulse_q <= cfg_data_i[PB-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake
  logic     s1_valid_q;
  logic     out_valid_q;
  logic     s1_adv;
  logic     in_acc;
  logic     tick_acc;
  logic     load_acc;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign tick_acc   = in_acc && (command_i == wss_pkg::CMD_TICK);
  assign load_acc   = in_acc && (command_i == wss_pkg::CMD_LOAD);

  // ---------------------------------------------------------------- window stage
  logic [IW-1:0]      pos_q;
  logic               run_q;
  logic               run_d;
  logic [IW-1:0]      start_sat;
  logic signed [9:0]  len_ext;
  logic signed [9:0]  len_sat;
  logic               rev;
  logic signed [10:0] end_sum;
  logic signed [10:0] end_wrap;
  logic [IW-1:0]      lo;
  logic [IW-1:0]      hi;
  logic [IW-1:0]      pos_a;
  logic [IW-1:0]      pos_step;
  logic [IW-1:0]      pos_b;
  logic [IW-1:0]      pos_d;
  logic               stepped;
  logic               eos_fire;
  logic [15:0]        filt_mag;
  logic [VB+15:0]     filt_wide;
  logic [VB:0]        bound;
  logic [VB:0]        vmin;
  logic [VB:0]        vmax;

  always_comb begin
    run_d     = run_q ^ run_toggle_i;
    start_sat = (int'(start_index_i) >= SEQ_LENGTH) ? LAST : IW'(start_index_i);
    len_ext   = 10'(window_length_i);
    if (len_ext > LEN_MAX) begin
      len_sat = LEN_MAX;
    end else if (len_ext < -LEN_MAX) begin
      len_sat = -LEN_MAX;
    end else begin
      len_sat = len_ext;
    end
    rev     = len_sat[9];
    end_sum = 11'($signed({1'b0, start_sat})) + 11'(len_sat);
    if (end_sum < 0) begin
      end_wrap = end_sum + NSTEPS;
    end else if (end_sum >= NSTEPS) begin
      end_wrap = end_sum - NSTEPS;
    end else begin
      end_wrap = end_sum;
    end
    lo = rev ? end_wrap[IW-1:0] : start_sat;
    hi = rev ? start_sat : end_wrap[IW-1:0];

    // The entry step is the window start in either direction.
    pos_a = in_win(pos_q, lo, hi) ? pos_q : start_sat;
    if (rev) begin
      pos_step = (pos_a == '0) ? LAST : pos_a - IW'(1);
    end else begin
      pos_step = (pos_a == LAST) ? '0 : pos_a + IW'(1);
    end
    stepped  = run_d && clock_edge_i;
    eos_fire = 1'b0;
    pos_b    = pos_a;
    if (stepped) begin
      if (in_win(pos_step, lo, hi)) begin
        pos_b = pos_step;
      end else begin
        pos_b    = start_sat;
        eos_fire = 1'b1;
      end
    end
    pos_d = reset_edge_i ? start_sat : pos_b;

    // Filter bounds as fractions of VB bits, inclusive.
    if (filter_level_i > 0) begin
      filt_mag = 16'(filter_level_i);
    end else begin
      filt_mag = 16'(-filter_level_i);
    end
    filt_wide = {filt_mag, {VB{1'b0}}} >> 15;
    bound     = filt_wide[VB:0];
    vmin      = (filter_level_i > 0) ? bound : '0;
    vmax      = (filter_level_i < 0) ? ONE - bound : ONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      run_q <= 1'b0;
    end else if (tick_acc) begin
      pos_q <= pos_d;
      run_q <= run_d;
    end
  end

  // ---------------------------------------------------------------- step value store
  logic [SEQ_LENGTH-1:0] vld_q;
  logic                  vld_a_q;
  logic                  vld_b_q;
  logic                  wr_en;
  logic [IW-1:0]         waddr;
  logic [VB-1:0]         wdata;
  logic [VB-1:0]         rdata_a;
  logic [VB-1:0]         rdata_b;

  assign wr_en = load_acc && (int'(load_address_i) < SEQ_LENGTH);
  assign waddr = IW'(load_address_i);
  assign wdata = VB'(load_value_i);

  wss_ram #(
    .WIDTH (VB),
    .DEPTH (SEQ_LENGTH)
  ) u_values (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .re_i      (tick_acc),
    .raddr_a_i (pos_b),
    .raddr_b_i (pos_d),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // A step that was never loaded reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[waddr] <= 1'b1;
      end
      if (tick_acc) begin
        vld_a_q <= vld_q[pos_b];
        vld_b_q <= vld_q[pos_d];
      end
    end
  end

  // ---------------------------------------------------------------- stage 1 registers
  wss_pkg::s1_ctrl_t s1_ctrl_q;
  logic [IW-1:0]     s1_pos_q;
  logic              s1_run_q;
  logic [VB:0]       s1_vmin_q;
  logic [VB:0]       s1_vmax_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_ctrl_q.is_load  <= (command_i == wss_pkg::CMD_LOAD);
      s1_ctrl_q.stepped  <= stepped;
      s1_ctrl_q.eos_fire <= eos_fire;
      s1_pos_q           <= (command_i == wss_pkg::CMD_LOAD) ? pos_q : pos_d;
      s1_run_q           <= (command_i == wss_pkg::CMD_LOAD) ? run_q : run_d;
      s1_vmin_q          <= vmin;
      s1_vmax_q          <= vmax;
    end
  end

  // ---------------------------------------------------------------- output stage
  logic [PB-1:0]            eos_q;
  logic [PB-1:0]            trig_q;
  logic [TB-1:0]            since_q;
  logic [TB-1:0]            gel_q;
  logic [TB-1:0]            glim_q;
  logic                     gate_on_q;
  logic                     seen_q;

  logic [VB-1:0]            raw_a;
  logic [VB-1:0]            raw_b;
  logic [VB-1:0]            val;
  logic                     trig_fire;
  logic [PB-1:0]            eos_arm;
  logic [PB-1:0]            trig_arm;
  logic                     hit_eos;
  logic                     hit_trig;
  logic [PB-1:0]            eos_d;
  logic [PB-1:0]            trig_d;
  logic signed [VB+1:0]     opa;
  logic signed [16:0]       opb;
  logic signed [VB+18:0]    cv_prod;
  logic signed [15:0]       cv;
  logic [TB-1:0]            since_inc;
  logic [TB-1:0]            gel_inc;
  logic [TB+VB-1:0]         gprod;
  logic [TB+VB-1:0]         gsum;
  logic [TB-1:0]            since_d;
  logic [TB-1:0]            gel_d;
  logic [TB-1:0]            glim_d;
  logic                     gate_on_d;
  logic                     seen_d;

  always_comb begin
    raw_a = vld_a_q ? rdata_a : '0;
    raw_b = vld_b_q ? rdata_b : '0;
    trig_fire = s1_ctrl_q.stepped && (raw_a != '0) &&
                ({1'b0, raw_a} >= s1_vmin_q) && ({1'b0, raw_a} <= s1_vmax_q);
    val = (({1'b0, raw_b} >= s1_vmin_q) && ({1'b0, raw_b} <= s1_vmax_q)) ? raw_b : '0;

    // Pulse timers are raised to the pulse length, never lowered.
    eos_arm  = (s1_ctrl_q.eos_fire && (pulse_q > eos_q)) ? pulse_q : eos_q;
    trig_arm = (trig_fire && (pulse_q > trig_q)) ? pulse_q : trig_q;
    hit_eos  = (eos_arm != '0);
    hit_trig = (trig_arm != '0);
    eos_d    = hit_eos ? eos_arm - PB'(1) : '0;
    trig_d   = hit_trig ? trig_arm - PB'(1) : '0;

    // Negative scale gives a bipolar output centred on half scale.
    if (scale_q[15]) begin
      opa = $signed({2'b00, val}) - HALF;
      opb = -17'(scale_q);
    end else begin
      opa = $signed({2'b00, val});
      opb = 17'(scale_q);
    end
    cv_prod = opa * opb;
    cv      = 16'(cv_prod >>> VB);

    since_inc = (since_q == TMAX) ? since_q : since_q + TB'(1);
    gel_inc   = (gel_q == TMAX) ? gel_q : gel_q + TB'(1);
    gprod     = since_inc * val;
    gsum      = gprod + (TB+VB)'(MASK);

    since_d   = since_inc;
    gel_d     = gel_q;
    glim_d    = glim_q;
    gate_on_d = gate_on_q;
    seen_d    = seen_q;
    if (gate_on_q) begin
      gel_d = gel_inc;
      if (gel_inc >= glim_q) begin
        gate_on_d = 1'b0;
      end
    end
    if (s1_ctrl_q.stepped) begin
      if (seen_q) begin
        gel_d     = '0;
        glim_d    = gsum[TB+VB-1:VB];
        // The rounded-up limit is nonzero exactly when the value is nonzero.
        gate_on_d = (val != '0);
      end else begin
        seen_d = 1'b1;
      end
      since_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eos_q     <= '0;
      trig_q    <= '0;
      since_q   <= '0;
      gel_q     <= '0;
      glim_q    <= '0;
      gate_on_q <= 1'b0;
      seen_q    <= 1'b0;
    end else if (s1_adv && !s1_ctrl_q.is_load) begin
      eos_q     <= eos_d;
      trig_q    <= trig_d;
      since_q   <= since_d;
      gel_q     <= gel_d;
      glim_q    <= glim_d;
      gate_on_q <= gate_on_d;
      seen_q    <= seen_d;
    end
  end

  // ---------------------------------------------------------------- result register
  logic [4:0]  step_q;
  logic [15:0] cv_q;
  logic        gate_q;
  logic        eos_out_q;
  logic        trig_out_q;
  logic        run_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // A load transaction reports position and run flag only.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      step_q     <= 5'(s1_pos_q);
      run_out_q  <= s1_run_q;
      cv_q       <= s1_ctrl_q.is_load ? '0 : cv;
      gate_q     <= !s1_ctrl_q.is_load && gate_on_d;
      eos_out_q  <= !s1_ctrl_q.is_load && hit_eos;
      trig_out_q <= !s1_ctrl_q.is_load && hit_trig;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign current_step_o    = step_q;
  assign cv_out_o          = $signed(cv_q);
  assign gate_o            = gate_q;
  assign end_of_sequence_o = eos_out_q;
  assign trigger_o         = trig_out_q;
  assign run_active_o      = run_out_q;

  // ---------------------------------------------------------------- assertions
  `WSS_ASSERT(a_gate_has_limit, clk_i, rst_ni, gate_on_q |-> (glim_q != '0), "gate open with zero limit")
  `WSS_ASSERT(a_load_keeps_pos, clk_i, rst_ni, load_acc |=> (pos_q == $past(pos_q)), "load moved position")
  `WSS_ASSERT(a_empty_accepts, clk_i, rst_ni, !s1_valid_q |-> !in_stall_o, "stall with empty stage")

endmodule
